// ===== design/mtt_pkg.sv =====
`default_nettype none

package mtt_pkg;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_TEXT     = 4'd1,
        PH_AFTER_LT = 4'd2,
        PH_CLOSE    = 4'd3,
        PH_OPEN     = 4'd4,
        PH_ATTR_WS  = 4'd5,
        PH_ATTR     = 4'd6,
        PH_VAL_WS   = 4'd7,
        PH_VAL_Q    = 4'd8
    } phase_t;

    localparam logic [2:0] ROLE_SKIP      = 3'd0;
    localparam logic [2:0] ROLE_TEXT      = 3'd1;
    localparam logic [2:0] ROLE_OPEN_NAME = 3'd2;
    localparam logic [2:0] ROLE_CLOSENAME = 3'd3;
    localparam logic [2:0] ROLE_ATTR_NAME = 3'd4;
    localparam logic [2:0] ROLE_ATTR_VAL  = 3'd5;
    localparam logic [2:0] ROLE_DELIM     = 3'd6;

    localparam logic [1:0] TB_NONE  = 2'd0;
    localparam logic [1:0] TB_TEXT  = 2'd1;
    localparam logic [1:0] TB_OPEN  = 2'd2;
    localparam logic [1:0] TB_CLOSE = 2'd3;

    localparam logic [2:0] TE_NONE       = 3'd0;
    localparam logic [2:0] TE_TEXT_BEFORE = 3'd1;
    localparam logic [2:0] TE_OPEN       = 3'd2;
    localparam logic [2:0] TE_CLOSE      = 3'd3;
    localparam logic [2:0] TE_TEXT_AFTER = 3'd4;
    localparam logic [2:0] TE_CUT        = 3'd5;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_QUOTED = 2'd2;
    localparam logic [1:0] ST_CUT    = 2'd3;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef struct packed {
        logic [2:0] role;
        logic [1:0] token_begins;
        logic [2:0] token_ends;
        logic       name_begins;
        logic       empty_name;
        logic [1:0] attr_store;
    } result_t;

endpackage

`default_nettype wire

// ===== design/mtt_step.sv =====
`default_nettype none

module mtt_step (
    input  wire mtt_pkg::phase_t  phase,
    input  wire logic             name_seen,
    input  wire logic [7:0]       char_in,
    input  wire logic             last_byte,
    output mtt_pkg::result_t      result,
    output mtt_pkg::phase_t       phase_next,
    output logic                  name_seen_next
);

    typedef struct packed {
        mtt_pkg::result_t res;
        mtt_pkg::phase_t  ph;
        logic             ns;
        logic             again;
    } pass_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90)
            || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic pass_t do_pass(input mtt_pkg::phase_t ph, input logic ns,
                                      input logic [7:0] c);
        pass_t p;
        p       = '0;
        p.ph    = ph;
        p.ns    = ns;
        case (ph)
            mtt_pkg::PH_IDLE:
            begin
                if (is_ws(c)) begin
                    p.res.role = mtt_pkg::ROLE_SKIP;
                end else if (c == mtt_pkg::CH_LT) begin
                    p.res.role = mtt_pkg::ROLE_DELIM;
                    p.ph       = mtt_pkg::PH_AFTER_LT;
                end else begin
                    p.res.role         = mtt_pkg::ROLE_TEXT;
                    p.res.token_begins = mtt_pkg::TB_TEXT;
                    p.ph               = mtt_pkg::PH_TEXT;
                end
            end
            mtt_pkg::PH_TEXT:
            begin
                if (c == mtt_pkg::CH_LT) begin
                    p.res.role       = mtt_pkg::ROLE_DELIM;
                    p.res.token_ends = mtt_pkg::TE_TEXT_BEFORE;
                    p.ph             = mtt_pkg::PH_AFTER_LT;
                end else begin
                    p.res.role = mtt_pkg::ROLE_TEXT;
                end
            end
            mtt_pkg::PH_AFTER_LT:
            begin
                if (c == mtt_pkg::CH_SLASH) begin
                    p.res.role         = mtt_pkg::ROLE_DELIM;
                    p.res.token_begins = mtt_pkg::TB_CLOSE;
                    p.ph               = mtt_pkg::PH_CLOSE;
                end else begin
                    p.res.token_begins = mtt_pkg::TB_OPEN;
                    p.ph               = mtt_pkg::PH_OPEN;
                    p.again            = 1'b1;
                end
            end
            mtt_pkg::PH_CLOSE:
            begin
                if (c == mtt_pkg::CH_GT) begin
                    p.res.role       = mtt_pkg::ROLE_DELIM;
                    p.res.token_ends = mtt_pkg::TE_CLOSE;
                    p.ph             = mtt_pkg::PH_IDLE;
                end else begin
                    p.res.role = mtt_pkg::ROLE_CLOSENAME;
                end
            end
            mtt_pkg::PH_OPEN:
            begin
                if (is_ws(c)) begin
                    p.res.role = mtt_pkg::ROLE_SKIP;
                    p.ns       = 1'b0;
                    p.ph       = mtt_pkg::PH_ATTR_WS;
                end else if (c == mtt_pkg::CH_GT) begin
                    p.res.role       = mtt_pkg::ROLE_DELIM;
                    p.res.token_ends = mtt_pkg::TE_OPEN;
                    p.ph             = mtt_pkg::PH_IDLE;
                end else begin
                    p.res.role = mtt_pkg::ROLE_OPEN_NAME;
                end
            end
            mtt_pkg::PH_ATTR_WS, mtt_pkg::PH_ATTR:
            begin
                if (c == mtt_pkg::CH_GT) begin
                    p.res.role       = mtt_pkg::ROLE_DELIM;
                    p.res.token_ends = mtt_pkg::TE_OPEN;
                    p.ph             = mtt_pkg::PH_IDLE;
                    p.ns             = 1'b0;
                end else if (c == mtt_pkg::CH_EQ) begin
                    p.res.role       = mtt_pkg::ROLE_DELIM;
                    p.res.empty_name = ~ns;
                    p.ns             = 1'b0;
                    p.ph             = mtt_pkg::PH_VAL_WS;
                end else if (is_alnum(c)) begin
                    p.res.role        = mtt_pkg::ROLE_ATTR_NAME;
                    p.res.name_begins = (ph == mtt_pkg::PH_ATTR_WS);
                    p.ns              = 1'b1;
                    p.ph              = mtt_pkg::PH_ATTR;
                end else if (is_ws(c)) begin
                    p.res.role = mtt_pkg::ROLE_SKIP;
                    p.ph       = mtt_pkg::PH_ATTR_WS;
                end else begin
                    p.res.role = mtt_pkg::ROLE_SKIP;
                end
            end
            mtt_pkg::PH_VAL_WS:
            begin
                if (is_ws(c)) begin
                    p.res.role = mtt_pkg::ROLE_SKIP;
                end else if (c == mtt_pkg::CH_QUOTE) begin
                    p.res.role = mtt_pkg::ROLE_DELIM;
                    p.ph       = mtt_pkg::PH_VAL_Q;
                end else begin
                    p.res.attr_store = mtt_pkg::ST_EMPTY;
                    p.ns             = 1'b0;
                    p.ph             = mtt_pkg::PH_ATTR_WS;
                    p.again          = 1'b1;
                end
            end
            mtt_pkg::PH_VAL_Q:
            begin
                if (c == mtt_pkg::CH_QUOTE) begin
                    p.res.role       = mtt_pkg::ROLE_DELIM;
                    p.res.attr_store = mtt_pkg::ST_QUOTED;
                    p.ns             = 1'b0;
                    p.ph             = mtt_pkg::PH_ATTR_WS;
                end else begin
                    p.res.role = mtt_pkg::ROLE_ATTR_VAL;
                end
            end
            default:
            begin
                p.ph = mtt_pkg::PH_IDLE;
                p.ns = 1'b0;
            end
        endcase
        return p;
    endfunction

    pass_t            first_pass;
    pass_t            second_pass;
    mtt_pkg::result_t merged;
    mtt_pkg::phase_t  merged_ph;
    logic             merged_ns;

    // a re-handled byte never carries a role from its first pass, so events merge by OR
    always_comb
    begin
        first_pass  = do_pass(phase, name_seen, char_in);
        second_pass = do_pass(first_pass.ph, first_pass.ns, char_in);
        if (first_pass.again) begin
            merged    = first_pass.res | second_pass.res;
            merged_ph = second_pass.ph;
            merged_ns = second_pass.ns;
        end else begin
            merged    = first_pass.res;
            merged_ph = first_pass.ph;
            merged_ns = first_pass.ns;
        end
    end

    always_comb
    begin
        result         = merged;
        phase_next     = merged_ph;
        name_seen_next = merged_ns;
        if (last_byte) begin
            if (merged_ph == mtt_pkg::PH_VAL_Q) begin
                result.attr_store = mtt_pkg::ST_CUT;
            end else if (merged_ph == mtt_pkg::PH_VAL_WS) begin
                result.attr_store = mtt_pkg::ST_EMPTY;
            end
            if (merged_ph == mtt_pkg::PH_TEXT) begin
                result.token_ends = mtt_pkg::TE_TEXT_AFTER;
            end else if (merged_ph != mtt_pkg::PH_IDLE) begin
                result.token_ends = mtt_pkg::TE_CUT;
            end
            if (merged_ph == mtt_pkg::PH_AFTER_LT) begin
                result.token_begins = mtt_pkg::TB_OPEN;
            end
            phase_next     = mtt_pkg::PH_IDLE;
            name_seen_next = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== design/markup_tag_tokenizer_unit.sv =====
// Channel  Handshake            Beat contents
// in       in_valid/in_stall    char_in, last_byte
// out      out_valid/out_stall  byte_value, role, token_begins, token_ends,
//                               name_begins, empty_name, attr_store, stream_done
//
// One beat in per cycle, one beat out per cycle, while out_stall is low.
// The parse phase advances as a byte moves from the input register to the result
// register; that step, taken only when the result register is free, sets the rate.
// rst_n clears valids and the phase to between-tokens; last_byte also returns it there.
// out_stall holds the result register and, once that is full, the input register.
`default_nettype none

module markup_tag_tokenizer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_in,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      byte_value,
    output logic [2:0]      role,
    output logic [1:0]      token_begins,
    output logic [2:0]      token_ends,
    output logic            name_begins,
    output logic            empty_name,
    output logic [1:0]      attr_store,
    output logic            stream_done
);

    logic             s1_valid_reg;
    logic [7:0]       s1_char_reg;
    logic             s1_last_reg;
    mtt_pkg::phase_t  phase_reg;
    mtt_pkg::phase_t  phase_next;
    logic             name_seen_reg;
    logic             name_seen_next;
    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic             out_last_reg;
    mtt_pkg::result_t out_result_reg;
    mtt_pkg::result_t result;
    logic             out_free;
    logic             s1_move;

    assign out_free = ~out_valid_reg | ~out_stall;
    assign s1_move  = s1_valid_reg & out_free;
    assign in_stall = s1_valid_reg & ~out_free;

    mtt_step u_step (
        .phase          (phase_reg),
        .name_seen      (name_seen_reg),
        .char_in        (s1_char_reg),
        .last_byte      (s1_last_reg),
        .result         (result),
        .phase_next     (phase_next),
        .name_seen_next (name_seen_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= mtt_pkg::PH_IDLE;
            name_seen_reg <= 1'b0;
        end else begin
            if (!in_stall) begin
                s1_valid_reg <= in_valid;
            end
            if (out_free) begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_move) begin
                phase_reg     <= phase_next;
                name_seen_reg <= name_seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid) begin
            s1_char_reg <= char_in;
            s1_last_reg <= last_byte;
        end
        if (s1_move) begin
            out_char_reg   <= s1_char_reg;
            out_last_reg   <= s1_last_reg;
            out_result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_value   = out_char_reg;
    assign role         = out_result_reg.role;
    assign token_begins = out_result_reg.token_begins;
    assign token_ends   = out_result_reg.token_ends;
    assign name_begins  = out_result_reg.name_begins;
    assign empty_name   = out_result_reg.empty_name;
    assign attr_store   = out_result_reg.attr_store;
    assign stream_done  = out_last_reg;

endmodule

`default_nettype wire
